>>> rtl/core/txrt_pkg.sv
package txrt_pkg;

   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_CHECK   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   // One table slot as stored in memory.
   typedef struct packed {
      logic        valid;
      logic [31:0] relation;
      logic [47:0] location;
      logic [31:0] holder;
   } entry_type;

   // One request as captured at the input transfer.
   typedef struct packed {
      logic [1:0]  op;
      logic        table_sel;
      logic [31:0] relation;
      logic [47:0] location;
      logic [31:0] tx_id;
   } request_type;

endpackage

>>> rtl/core/tx_reservation_table_unit.sv
// Reservation table unit. Two keyed tables (write set, read set) live in one
// synchronous memory of 2*TABLE_ENTRIES slots and map a tuple key to the lowest
// transaction id that reserved it. Every reserve, check or release scans the
// selected table one slot at a time through the single memory port, reading a
// slot and then comparing it, and stops at the first match or at the last slot.
// A clear sweeps the whole memory, one slot a cycle. After reset the same sweep
// runs before the first request is taken (req_tready stays low during it).
// One request is in work at a time; the result waits in an output register
// while the next request is already accepted.
module tx_reservation_table_unit
   import txrt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] relation, [63:32] block_number, [79:64] item_offset, [111:80] tx_id
   input  logic [111:0] req_tdata,
   // [1:0] op, [2] table_sel
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] granted, [1] conflict, [2] holder_present, [34:3] holder_tx_id,
   // [35] table_full, [39:36] zero
   output logic [39:0]  rsp_tdata
);

   localparam int DEPTH = 2 * TABLE_ENTRIES;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(TABLE_ENTRIES);
   localparam int CW    = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   entry_type   mem [DEPTH];
   entry_type   rd_ff;

   logic [2:0]  state_ff, state_in;
   request_type req_ff;
   logic [IW-1:0] idx_ff;
   logic [AW-1:0] clr_ff;
   logic        clr_rsp_ff;
   logic        found_ff, free_ok_ff;
   logic [AW-1:0] slot_ff, free_ff;
   logic [31:0] hold_ff;
   logic [CW-1:0] count_ff [2];
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic [AW-1:0] scan_addr;
   logic        we;
   logic [AW-1:0] waddr;
   entry_type   wdata;
   logic        fin_go, hit, last_idx, is_full;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign scan_addr = (req_ff.table_sel ? AW'(TABLE_ENTRIES) : AW'(0)) + AW'(idx_ff);
   assign hit       = rd_ff.valid && rd_ff.relation == req_ff.relation
                      && rd_ff.location == req_ff.location;
   assign last_idx  = (idx_ff == IW'(TABLE_ENTRIES - 1));
   assign fin_go    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);
   assign is_full   = (count_ff[req_ff.table_sel] == CW'(TABLE_ENTRIES)) || !free_ok_ff;

   // Memory: one write, one registered read a cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[scan_addr];
   end

   // Write port and result of the finishing step.
   always_comb begin
      we          = 1'b0;
      waddr       = slot_ff;
      wdata       = '{valid: 1'b1, relation: req_ff.relation,
                      location: req_ff.location, holder: req_ff.tx_id};
      rsp_data_in = '0;
      if (state_ff == S_CLR) begin
         we    = 1'b1;
         waddr = clr_ff;
         wdata = '0;
      end else if (fin_go) begin
         unique case (req_ff.op)
            OP_RESERVE: begin
               if (found_ff) begin
                  // Lower the holder when the caller's id is strictly lower.
                  we = (hold_ff > req_ff.tx_id);
                  rsp_data_in[0] = (hold_ff >= req_ff.tx_id);
                  rsp_data_in[2] = 1'b1;
                  rsp_data_in[34:3] = (hold_ff > req_ff.tx_id) ? req_ff.tx_id : hold_ff;
               end else if (is_full) begin
                  rsp_data_in[35] = 1'b1;
               end else begin
                  we    = 1'b1;
                  waddr = free_ff;
                  rsp_data_in[0] = 1'b1;
                  rsp_data_in[2] = 1'b1;
                  rsp_data_in[34:3] = req_ff.tx_id;
               end
            end
            OP_CHECK: begin
               if (found_ff) begin
                  rsp_data_in[1] = (hold_ff < req_ff.tx_id);
                  rsp_data_in[2] = 1'b1;
                  rsp_data_in[34:3] = hold_ff;
               end
            end
            OP_RELEASE: begin
               if (found_ff && hold_ff == req_ff.tx_id) begin
                  we          = 1'b1;
                  wdata.valid = 1'b0;
                  rsp_data_in[0] = 1'b1;
               end else if (found_ff) begin
                  rsp_data_in[2] = 1'b1;
                  rsp_data_in[34:3] = hold_ff;
               end
            end
            default: begin
               rsp_data_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:  if (clr_ff == AW'(DEPTH - 1)) state_in = clr_rsp_ff ? S_FIN : S_IDLE;
         S_IDLE: if (req_tvalid) state_in = (req_tuser[1:0] == OP_CLEAR) ? S_CLR : S_RD;
         S_RD:   state_in = S_CMP;
         S_CMP:  if (hit || last_idx) state_in = S_FIN; else state_in = S_RD;
         S_FIN:  if (fin_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff[0]  <= '0;
         count_ff[1]  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) begin
            clr_ff <= clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               count_ff[0] <= '0;
               count_ff[1] <= '0;
            end
         end
         if (state_ff == S_IDLE && req_tvalid) begin
            clr_ff     <= '0;
            clr_rsp_ff <= 1'b1;
         end
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // Track occupancy on insert and on removal.
         if (fin_go && req_ff.op == OP_RESERVE && !found_ff && !is_full) begin
            count_ff[req_ff.table_sel] <= count_ff[req_ff.table_sel] + CW'(1);
         end
         if (fin_go && req_ff.op == OP_RELEASE && found_ff && hold_ff == req_ff.tx_id
             && count_ff[req_ff.table_sel] != '0) begin
            count_ff[req_ff.table_sel] <= count_ff[req_ff.table_sel] - CW'(1);
         end
      end
   end

   // Request capture and scan bookkeeping.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         req_ff     <= '{op: req_tuser[1:0], table_sel: req_tuser[2],
                         relation: req_tdata[31:0],
                         location: {req_tdata[63:32], req_tdata[79:64]},
                         tx_id: req_tdata[111:80]};
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         free_ok_ff <= 1'b0;
      end
      if (state_ff == S_CMP) begin
         if (hit) begin
            found_ff <= 1'b1;
            slot_ff  <= scan_addr;
            hold_ff  <= rd_ff.holder;
         end else begin
            if (!rd_ff.valid && !free_ok_ff) begin
               free_ok_ff <= 1'b1;
               free_ff    <= scan_addr;
            end
            if (!last_idx) begin
               idx_ff <= idx_ff + IW'(1);
            end
         end
      end
      if (fin_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> rtl/core/txrt_checker.sv
module txrt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("result or ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in work");

   a_full_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> !rsp_tdata[0] && !rsp_tdata[2])
      else $error("refused reserve reports a holder");

   a_conflict_present: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[2])
      else $error("conflict without holder");

endmodule

bind tx_reservation_table_unit txrt_checker u_txrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/tx_reservation_table_unit_tb.sv
module tx_reservation_table_unit_tb
   import txrt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES = 1024;
   // Longest item: a full sweep of both tables, then the result.
   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_ITEMS  = 780;
   localparam int KEY_POOL      = 12;

   // Expected contents of one result transfer.
   typedef struct packed {
      logic        granted;
      logic        conflict;
      logic        holder_present;
      logic [31:0] holder_tx_id;
      logic        table_full;
   } outcome_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;

   tx_reservation_table_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Requests waiting to be driven, and outcomes waiting for their transfer.
   request_type pending_reqs[$];
   outcome_type expected_outcomes[$];
   request_type in_flight;

   // Shadow of both tables: key {table_sel, relation, location} -> holder.
   logic [31:0] shadow_holder [logic [80:0]];
   int          shadow_count [2];

   int  error_count;
   int  accepted_count;
   int  stall_cycles;
   bit  calm_window;

   // Pool of keys reused by the random part so that hits are frequent.
   logic [31:0] pool_relation [KEY_POOL];
   logic [47:0] pool_location [KEY_POOL];
   logic [31:0] pool_tx [8];

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Compute the outcome of one request and update the shadow tables.
   function automatic outcome_type apply_request(input request_type rq);
      outcome_type res;
      logic [80:0] key;
      res = '0;
      key = {rq.table_sel, rq.relation, rq.location};
      if (rq.op == OP_CLEAR) begin
         shadow_holder.delete();
         shadow_count[0] = 0;
         shadow_count[1] = 0;
      end else if (rq.op == OP_RESERVE) begin
         if (shadow_holder.exists(key)) begin
            // lower the holder when the caller is older
            if (shadow_holder[key] > rq.tx_id) shadow_holder[key] = rq.tx_id;
            res.granted = (shadow_holder[key] == rq.tx_id);
            res.holder_present = 1'b1;
            res.holder_tx_id = shadow_holder[key];
         end else if (shadow_count[rq.table_sel] >= TABLE_ENTRIES) begin
            res.table_full = 1'b1;
         end else begin
            shadow_holder[key] = rq.tx_id;
            shadow_count[rq.table_sel]++;
            res.granted = 1'b1;
            res.holder_present = 1'b1;
            res.holder_tx_id = rq.tx_id;
         end
      end else if (rq.op == OP_CHECK) begin
         if (shadow_holder.exists(key)) begin
            res.holder_present = 1'b1;
            res.holder_tx_id = shadow_holder[key];
            res.conflict = (shadow_holder[key] < rq.tx_id);
         end
      end else begin
         if (shadow_holder.exists(key)) begin
            if (shadow_holder[key] == rq.tx_id) begin
               shadow_holder.delete(key);
               shadow_count[rq.table_sel]--;
               res.granted = 1'b1;
            end else begin
               // non-holder release leaves the entry in place
               res.holder_present = 1'b1;
               res.holder_tx_id = shadow_holder[key];
            end
         end
      end
      return res;
   endfunction

   function automatic request_type make_request(input logic [1:0] op, input logic sel,
                                                input logic [31:0] rel, input logic [31:0] blk,
                                                input logic [15:0] off, input logic [31:0] tx);
      request_type rq;
      rq.op = op;
      rq.table_sel = sel;
      rq.relation = rel;
      rq.location = {blk, off};
      rq.tx_id = tx;
      return rq;
   endfunction

   // Driver: advance to the next request once the current one transfers.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(apply_request(in_flight));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && (calm_window || $urandom_range(99) >= 29)) begin
               in_flight = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {in_flight.tx_id, in_flight.location[15:0],
                              in_flight.location[47:16], in_flight.relation};
               req_tuser  <= {in_flight.table_sel, in_flight.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every result transfer with the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               $error("result transfer with no request outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_tdata[0] !== want.granted) begin
                  $error("granted: expected %0d, actual %0d", want.granted, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[1] !== want.conflict) begin
                  $error("conflict: expected %0d, actual %0d", want.conflict, rsp_tdata[1]);
                  error_count++;
               end
               if (rsp_tdata[2] !== want.holder_present) begin
                  $error("holder_present: expected %0d, actual %0d", want.holder_present,
                         rsp_tdata[2]);
                  error_count++;
               end
               if (rsp_tdata[34:3] !== want.holder_tx_id) begin
                  $error("holder_tx_id: expected %h, actual %h", want.holder_tx_id,
                         rsp_tdata[34:3]);
                  error_count++;
               end
               if (rsp_tdata[35] !== want.table_full) begin
                  $error("table_full: expected %0d, actual %0d", want.table_full,
                         rsp_tdata[35]);
                  error_count++;
               end
            end
         end
         rsp_tready <= calm_window || ($urandom_range(99) >= 29);
      end
   end

   // Watchdog: count cycles without any transfer on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Hold until every queued request has transferred and every result has come.
   task automatic drain_all();
      while (pending_reqs.size() > 0 || req_tvalid || expected_outcomes.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] rel_a;
      logic [31:0] blk_a;
      logic [15:0] off_a;
      int          pick;
      logic [1:0]  op;
      logic        sel;
      logic [31:0] rel;
      logic [31:0] blk;
      logic [15:0] off;
      logic [31:0] tx;
      error_count = 0;
      accepted_count = 0;
      stall_cycles = 0;
      calm_window = 1'b0;
      shadow_count[0] = 0;
      shadow_count[1] = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reserve, lowering, equal ids, conflicts, releases, extremes, clear.
      rel_a = $urandom;
      blk_a = $urandom;
      off_a = 16'($urandom);
      pending_reqs.push_back(make_request(OP_RESERVE, 1'b0, rel_a, blk_a, off_a, 32'd100));
      pending_reqs.push_back(make_request(OP_RESERVE, 1'b0, rel_a, blk_a, off_a, 32'd100));
      pending_reqs.push_back(make_request(OP_RESERVE, 1'b0, rel_a, blk_a, off_a, 32'd200));
      pending_reqs.push_back(make_request(OP_RESERVE, 1'b0, rel_a, blk_a, off_a, 32'd50));
      pending_reqs.push_back(make_request(OP_CHECK, 1'b0, rel_a, blk_a, off_a, 32'd50));
      pending_reqs.push_back(make_request(OP_CHECK, 1'b0, rel_a, blk_a, off_a, 32'd60));
      pending_reqs.push_back(make_request(OP_CHECK, 1'b0, rel_a, blk_a, off_a, 32'd10));
      pending_reqs.push_back(make_request(OP_CHECK, 1'b1, rel_a, blk_a, off_a, 32'd60));
      pending_reqs.push_back(make_request(OP_CHECK, 1'b0, rel_a, blk_a, off_a ^ 16'h1, 32'd60));
      pending_reqs.push_back(make_request(OP_RELEASE, 1'b0, rel_a, blk_a, off_a, 32'd60));
      pending_reqs.push_back(make_request(OP_RELEASE, 1'b0, rel_a, blk_a, off_a, 32'd50));
      pending_reqs.push_back(make_request(OP_RELEASE, 1'b0, rel_a, blk_a, off_a, 32'd50));
      pending_reqs.push_back(make_request(OP_RESERVE, 1'b1, '1, '1, '1, '1));
      pending_reqs.push_back(make_request(OP_RESERVE, 1'b1, '0, '0, '0, '0));
      pending_reqs.push_back(make_request(OP_CHECK, 1'b1, '1, '1, '1, '0));
      pending_reqs.push_back(make_request(OP_CHECK, 1'b1, '1, '1, '1, '1));
      pending_reqs.push_back(make_request(OP_RELEASE, 1'b1, '0, '0, '0, '0));
      pending_reqs.push_back(make_request(OP_CLEAR, 1'b1, '1, '1, '1, '1));
      pending_reqs.push_back(make_request(OP_CHECK, 1'b1, '1, '1, '1, '1));
      // pause the sender until the directed part has fully drained
      drain_all();

      // Random part: mostly pooled keys and ids so entries get hit and contended.
      foreach (pool_relation[i]) begin
         pool_relation[i] = $urandom;
         pool_location[i] = {$urandom, 16'($urandom)};
      end
      foreach (pool_tx[i]) pool_tx[i] = $urandom;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         op = (pick < 2) ? OP_CLEAR : (pick < 45) ? OP_RESERVE : (pick < 75) ? OP_CHECK
                                                                             : OP_RELEASE;
         sel = 1'($urandom_range(1));
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(KEY_POOL - 1);
            rel = pool_relation[pick];
            {blk, off} = pool_location[pick];
         end else begin
            rel = $urandom;
            blk = $urandom;
            off = 16'($urandom);
         end
         tx = ($urandom_range(99) < 85) ? pool_tx[$urandom_range(7)] : $urandom;
         pending_reqs.push_back(make_request(op, sel, rel, blk, off, tx));
      end
      // no idling on either side for a stretch in the middle of the random part
      while (accepted_count < 300 && pending_reqs.size() > 0) @(posedge clock);
      calm_window = 1'b1;
      while (accepted_count < 450 && pending_reqs.size() > 0) @(posedge clock);
      calm_window = 1'b0;

      drain_all();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_outcomes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/txrt_pkg.sv
rtl/core/tx_reservation_table_unit.sv
rtl/core/txrt_checker.sv
dv/tx_reservation_table_unit_tb.sv
